### rtl/rgbhsv_pkg.sv
// Package: shared constants and types for the RGB to HSV converter.
`default_nettype none
package rgbhsv_pkg;
  localparam int COLOR_BITS = 16;
  localparam int CHAN_W = 16;
  localparam int CFG_W = 16;
  localparam int VALUE_W = 32;
  localparam int SHIFT_W = 5;
  localparam int HUE_QBITS = 17;
  localparam int HUE_W = 16;

  localparam logic [CFG_W-1:0] MAX_COLOR_RST = 16'd255;
  localparam logic [CFG_W-1:0] MAX_HUE_RST = 16'd1536;
  localparam logic [SHIFT_W-1:0] EXTRA_BITS_RST = 5'd0;

  typedef enum logic [1:0] {
    REG_MAX_COLOR  = 2'd0,
    REG_MAX_HUE    = 2'd1,
    REG_EXTRA_BITS = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [CFG_W-1:0] max_color;
    logic [CFG_W-1:0] max_hue;
    logic [SHIFT_W-1:0] extra_bits;
  } cfg_t;

  typedef struct packed {
    logic zero;
    logic [VALUE_W-1:0] value;
  } side_t;
endpackage
`default_nettype wire

### rtl/rgb_to_hsv_converter.sv
// Top level: pixel stream RGB to integer HSV converter.
//
//  channel | dir | handshake         | payload
//  s_*     | in  | s_tvalid/s_tready | s_tdata: red, green, blue
//  m_*     | out | m_tvalid/m_tready | m_tdata: hue_out, saturation_out, value_out
//  cfg_*   | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One pixel per clock sustained while m_tready allows; data passes the front stages,
// the bit-per-stage dividers for hue and saturation, and the output register.
// Synchronous reset clears all valid bits and loads register defaults.
// A stall on m_tready freezes the whole pipeline; s_tready drops with it.
// cfg_ready is always high; registers are to be changed only while idle (not enforced).
`default_nettype none
module rgb_to_hsv_converter #(
  parameter int COLOR_BITS = rgbhsv_pkg::COLOR_BITS
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic s_tready,
  input  wire logic [47:0] s_tdata,   // red[15:0], green[31:16], blue[47:32]
  output logic m_tvalid,
  input  wire logic m_tready,
  output logic [63:0] m_tdata,        // hue_out[15:0], saturation_out[31:16], value_out[63:32]
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam int W = COLOR_BITS;
  localparam int Q = rgbhsv_pkg::HUE_QBITS;
  localparam int HN = rgbhsv_pkg::CFG_W + W + 3;

  rgbhsv_pkg::cfg_t cfg;
  logic en;
  logic fv;
  logic [HN-1:0] prod_h;
  logic [2*W-1:0] prod_s;
  logic [W+2:0] den_h;
  logic [W-1:0] den_s;
  rgbhsv_pkg::side_t fside;
  logic [Q-1:0] q_h, q_s;
  logic vpipe [1:Q];
  rgbhsv_pkg::side_t spipe [1:Q];
  logic [rgbhsv_pkg::HUE_W-1:0] hue_next;
  logic [Q-1:0] wrapped;

  // whole pipeline moves when the output slot is free or being taken
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;
  assign cfg_ready = 1'b1;

  rgbhsv_cfg u_cfg (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cfg(cfg)
  );

  rgbhsv_front #(.COLOR_BITS(W)) u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_tvalid),
    .red(s_tdata[15:0]), .green(s_tdata[31:16]), .blue(s_tdata[47:32]),
    .cfg(cfg), .out_valid(fv), .prod_h(prod_h), .prod_s(prod_s),
    .den_h(den_h), .den_s(den_s), .side(fside)
  );

  rgbhsv_div #(.NBITS(HN), .DBITS(W + 3), .QBITS(Q)) u_div_hue (
    .clk(clk), .en(en), .num(prod_h), .den(den_h), .quo(q_h)
  );

  rgbhsv_div #(.NBITS(2 * W), .DBITS(W), .QBITS(Q)) u_div_sat (
    .clk(clk), .en(en), .num(prod_s), .den(den_s), .quo(q_s)
  );

  // valid and sideband travel alongside the divider stages
  for (genvar i = 0; i < Q; i++) begin : g_side
    logic vin;
    rgbhsv_pkg::side_t sin;
    if (i == 0) begin : g_first
      assign vin = fv;
      assign sin = fside;
    end else begin : g_next
      assign vin = vpipe[i];
      assign sin = spipe[i];
    end
    always_ff @(posedge clk) begin
      if (rst) vpipe[i+1] <= 1'b0;
      else if (en) vpipe[i+1] <= vin;
      if (en) spipe[i+1] <= sin;
    end
  end

  // hue wraps once below max_hue; grey pixels give zero hue and saturation
  assign wrapped = (q_h >= Q'(cfg.max_hue)) ? q_h - Q'(cfg.max_hue) : q_h;
  assign hue_next = spipe[Q].zero ? '0 : wrapped[rgbhsv_pkg::HUE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= vpipe[Q];
    if (en) begin
      m_tdata[15:0] <= hue_next;
      m_tdata[31:16] <= spipe[Q].zero ? 16'd0 : q_s[15:0];
      m_tdata[63:32] <= spipe[Q].value;
    end
  end
endmodule
`default_nettype wire

### rtl/rgbhsv_cfg.sv
// Configuration register file.
`default_nettype none
module rgbhsv_cfg (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_valid,
  input  wire logic [1:0] cfg_index,
  input  wire logic [rgbhsv_pkg::CFG_W-1:0] cfg_data,
  output rgbhsv_pkg::cfg_t cfg
);
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_color <= rgbhsv_pkg::MAX_COLOR_RST;
      cfg.max_hue <= rgbhsv_pkg::MAX_HUE_RST;
      cfg.extra_bits <= rgbhsv_pkg::EXTRA_BITS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        rgbhsv_pkg::REG_MAX_COLOR: cfg.max_color <= cfg_data;
        rgbhsv_pkg::REG_MAX_HUE: cfg.max_hue <= cfg_data;
        rgbhsv_pkg::REG_EXTRA_BITS: cfg.extra_bits <= cfg_data[rgbhsv_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/rgbhsv_front.sv
// Front stages: clamp, max/min/chroma selection, scaling multiplies.
`default_nettype none
module rgbhsv_front #(
  parameter int COLOR_BITS = rgbhsv_pkg::COLOR_BITS
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_valid,
  input  wire logic [rgbhsv_pkg::CHAN_W-1:0] red,
  input  wire logic [rgbhsv_pkg::CHAN_W-1:0] green,
  input  wire logic [rgbhsv_pkg::CHAN_W-1:0] blue,
  input  rgbhsv_pkg::cfg_t cfg,
  output logic out_valid,
  output logic [rgbhsv_pkg::CFG_W+COLOR_BITS+2:0] prod_h,
  output logic [2*COLOR_BITS-1:0] prod_s,
  output logic [COLOR_BITS+2:0] den_h,
  output logic [COLOR_BITS-1:0] den_s,
  output rgbhsv_pkg::side_t side
);
  localparam int W = COLOR_BITS;
  localparam int NW = W + 3;

  logic [W-1:0] lim;
  logic [W-1:0] r1, g1, b1;
  logic v1, v2;
  logic [W-1:0] rr, gg, bb;
  logic [W-1:0] mx, mn, chroma;
  logic [NW-1:0] num;
  logic [W-1:0] mx2, chroma2;
  logic [NW-1:0] num2;

  assign lim = cfg.max_color[W-1:0];
  assign rr = (red[W-1:0] > lim) ? lim : red[W-1:0];
  assign gg = (green[W-1:0] > lim) ? lim : green[W-1:0];
  assign bb = (blue[W-1:0] > lim) ? lim : blue[W-1:0];

  // stage 1: clamped channels
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
    if (en) begin
      r1 <= rr;
      g1 <= gg;
      b1 <= bb;
    end
  end

  // red wins only when strictly largest; green wins ties with red
  always_comb begin
    if (r1 > g1 && r1 > b1) begin
      mx = r1;
      mn = (g1 < b1) ? g1 : b1;
    end else if (g1 >= r1 && g1 > b1) begin
      mx = g1;
      mn = (r1 < b1) ? r1 : b1;
    end else begin
      mx = b1;
      mn = (r1 < g1) ? r1 : g1;
    end
    chroma = mx - mn;
    if (r1 > g1 && r1 > b1)
      num = NW'(6) * NW'(chroma) + NW'(g1) - NW'(b1);
    else if (g1 >= r1 && g1 > b1)
      num = NW'(2) * NW'(chroma) + NW'(b1) - NW'(r1);
    else
      num = NW'(4) * NW'(chroma) + NW'(r1) - NW'(g1);
  end

  // stage 2: sector numerator and chroma
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      mx2 <= mx;
      chroma2 <= chroma;
      num2 <= num;
    end
  end

  // stage 3: products and divisors
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v2;
    if (en) begin
      prod_h <= (rgbhsv_pkg::CFG_W+NW)'(cfg.max_hue) * (rgbhsv_pkg::CFG_W+NW)'(num2);
      prod_s <= (2*W)'(lim) * (2*W)'(chroma2);
      den_h <= NW'(6) * NW'(chroma2);
      den_s <= mx2;
      side.zero <= (chroma2 == '0);
      side.value <= rgbhsv_pkg::VALUE_W'(mx2) << cfg.extra_bits;
    end
  end
endmodule
`default_nettype wire

### rtl/rgbhsv_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module rgbhsv_div #(
  parameter int NBITS = 35,
  parameter int DBITS = 19,
  parameter int QBITS = 17
) (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic [NBITS-1:0] num,
  input  wire logic [DBITS-1:0] den,
  output logic [QBITS-1:0] quo
);
  localparam int XW = (NBITS > DBITS + QBITS) ? NBITS : DBITS + QBITS;

  // stage j result lives at index j+1; the last stage keeps only its quotient
  logic [XW-1:0] rem [1:QBITS-1];
  logic [DBITS-1:0] dv [1:QBITS-1];
  logic [QBITS-1:0] qv [1:QBITS];

  for (genvar j = 0; j < QBITS; j++) begin : g_stage
    localparam int K = QBITS - 1 - j;
    logic [XW-1:0] rin;
    logic [DBITS-1:0] din;
    logic [QBITS-1:0] qin;
    logic [XW-1:0] sh;
    logic ge;
    if (j == 0) begin : g_first
      assign rin = XW'(num);
      assign din = den;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem[j];
      assign din = dv[j];
      assign qin = qv[j];
    end
    assign sh = XW'(din) << K;
    assign ge = rin >= sh;
    always_ff @(posedge clk) begin
      if (en) qv[j+1] <= qin | (QBITS'(ge) << K);
    end
    if (j < QBITS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[j+1] <= ge ? rin - sh : rin;
          dv[j+1] <= din;
        end
      end
    end
  end

  assign quo = qv[QBITS];
endmodule
`default_nettype wire

### rtl/rgbhsv_checker.sv
// Port-level checker for the converter, bound to the top level.
`default_nettype none
module rgbhsv_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_tready,
  input wire logic m_tvalid,
  input wire logic m_tready,
  input wire logic [63:0] m_tdata
);
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled request changed");
  a_take_when_empty: assert property (@(posedge clk) !m_tvalid |-> s_tready)
    else $error("input refused with empty output");
  a_stall_back: assert property (@(posedge clk) m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken during stall");
endmodule

bind rgb_to_hsv_converter rgbhsv_checker u_chk (
  .clk(clk), .rst(rst), .s_tready(s_tready), .m_tvalid(m_tvalid),
  .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
